FILE: design/h2r_pkg.sv
// Shared constants, types and stage-control struct for the HSV to RGB converter.
// Used by h2r_datapath and hsv_to_rgb_converter_top; depends on nothing else.
package h2r_pkg;

  // Fixed-point formats.
  localparam int unsigned HUE_FRAC_BITS   = 6;
  localparam int unsigned LEVEL_FRAC_BITS = 8;

  // Field widths of the stream items.
  localparam int unsigned HUE_W   = 15;
  localparam int unsigned LEVEL_W = 9;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned NUM_STAGES = 6;

  localparam int unsigned LEVEL_ONE   = 1 << LEVEL_FRAC_BITS;
  localparam int unsigned SECTOR_SPAN = 60 << HUE_FRAC_BITS;
  localparam int unsigned HUE_LIMIT   = 360 << HUE_FRAC_BITS;
  localparam int unsigned CHAN_MAX    = (1 << CHAN_W) - 1;

  // Internal widths.
  localparam int unsigned VS_W  = 2 * LEVEL_FRAC_BITS + 1;
  localparam int unsigned REM_W = $clog2(SECTOR_SPAN + 1);
  localparam int unsigned NUM_W = 2 * LEVEL_FRAC_BITS + REM_W;
  localparam int unsigned T_W   = NUM_W + CHAN_W;
  localparam int unsigned CC_W  = LEVEL_W + CHAN_W;
  localparam int unsigned ZC_W  = VS_W + CHAN_W;

  // The denominator 2^(2L) * 60 * 2^H splits into a power of two and 15.
  localparam int unsigned DIV_SHIFT   = 2 * LEVEL_FRAC_BITS + HUE_FRAC_BITS + 2;
  localparam int unsigned DIV_BASE    = SECTOR_SPAN >> (HUE_FRAC_BITS + 2);
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned DIV_MUL     = ((1 << RECIP_SHIFT) - 1) / DIV_BASE;
  localparam int unsigned D_W         = $clog2(CHAN_MAX * DIV_BASE + 1);
  localparam int unsigned MUL_W       = $clog2(DIV_MUL + 1);
  localparam int unsigned P_W         = D_W + MUL_W;
  localparam int unsigned Q_W         = D_W + MUL_W - RECIP_SHIFT;

  // Sixty-degree hue sectors, named by the colours at their ends.
  typedef enum logic [2:0] {
    SEC_RED_YELLOW    = 3'd0,
    SEC_YELLOW_GREEN  = 3'd1,
    SEC_GREEN_CYAN    = 3'd2,
    SEC_CYAN_BLUE     = 3'd3,
    SEC_BLUE_MAGENTA  = 3'd4,
    SEC_MAGENTA_RED   = 3'd5
  } sector_e;

  // Load enables of the pipeline stages, first stage first.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } h2r_ctrl_t;

endpackage

FILE: design/hsv_to_rgb_converter_top.sv
// Top level of the HSV to RGB converter: stream handshake and valid pipeline.
// Depends on h2r_pkg and h2r_datapath.
//
// The block takes one hue, saturation and brightness item on the slave stream
// and returns one red, green and blue item on the master stream, in order.
// Hue is in 1/64 degree and is clamped just below 360 degrees; saturation and
// brightness are Q1.8 and are clamped to 1.0. Each channel is floor(255 * level).
//
// The arithmetic is a six-stage pipeline whose last stage is the output
// register, and one item can be accepted in every cycle while the receiver
// keeps m_axis_tready high. The longest stage holds one 17 by 12 bit
// multiplication; the division by the sector span is a shift and a reciprocal
// multiply for the division by fifteen, with a one-step correction.
//
// Each stage has a valid bit and loads when it is empty or when the stage
// after it moves on, so bubbles close up while the output is stalled. When the
// receiver holds m_axis_tready low the result stays on m_axis_tdata, and
// s_axis_tready falls only once all six stages hold items. Reset clears the
// valid bits; the data registers are not reset. The block keeps no state
// between items.
module hsv_to_rgb_converter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // hue [14:0], saturation [23:15], brightness [32:24], zero [39:33]
  input  logic [h2r_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [h2r_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned SatLo = h2r_pkg::HUE_W;
  localparam int unsigned BriLo = h2r_pkg::HUE_W + h2r_pkg::LEVEL_W;

  logic [h2r_pkg::NUM_STAGES-1:0] vld_q;
  logic [h2r_pkg::NUM_STAGES-1:0] vld_d;
  logic [h2r_pkg::NUM_STAGES-1:0] en;
  h2r_pkg::h2r_ctrl_t             ctrl;

  logic [h2r_pkg::CHAN_W-1:0] red;
  logic [h2r_pkg::CHAN_W-1:0] green;
  logic [h2r_pkg::CHAN_W-1:0] blue;

  // A stage may load when it is empty or its content moves on this cycle.
  always_comb begin
    en[h2r_pkg::NUM_STAGES-1] = !vld_q[h2r_pkg::NUM_STAGES-1] || m_axis_tready;
    for (int k = h2r_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    for (int k = 0; k < h2r_pkg::NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = (k == 0) ? s_axis_tvalid : vld_q[(k == 0) ? 0 : k - 1];
      end else begin
        vld_d[k] = vld_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign ctrl = '{s1: en[0], s2: en[1], s3: en[2], s4: en[3], s5: en[4], s6: en[5]};

  h2r_datapath u_datapath (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .hue_i        (s_axis_tdata[h2r_pkg::HUE_W-1:0]),
    .saturation_i (s_axis_tdata[SatLo +: h2r_pkg::LEVEL_W]),
    .brightness_i (s_axis_tdata[BriLo +: h2r_pkg::LEVEL_W]),
    .red_o        (red),
    .green_o      (green),
    .blue_o       (blue)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[h2r_pkg::NUM_STAGES-1];
  assign m_axis_tdata  = {blue, green, red};

  // With no result waiting, the whole pipeline can move and must take an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  // Input is refused only when every stage holds an item behind a stall.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q) && !m_axis_tready)
    else $error("input stalled with a bubble in the pipeline");

  // An accepted item must occupy the first stage in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted item lost at the first stage");

  // A stalled middle stage keeps its item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[2] && !en[3] |=> vld_q[2])
    else $error("stalled stage dropped its item");

endmodule

FILE: design/h2r_datapath.sv
// Six-stage arithmetic pipeline of the HSV to RGB converter.
// Depends on h2r_pkg; stage loading is steered by the top level.
module h2r_datapath (
  input  logic                       clk_i,
  input  h2r_pkg::h2r_ctrl_t         ctrl_i,
  input  logic [h2r_pkg::HUE_W-1:0]   hue_i,
  input  logic [h2r_pkg::LEVEL_W-1:0] saturation_i,
  input  logic [h2r_pkg::LEVEL_W-1:0] brightness_i,
  output logic [h2r_pkg::CHAN_W-1:0]  red_o,
  output logic [h2r_pkg::CHAN_W-1:0]  green_o,
  output logic [h2r_pkg::CHAN_W-1:0]  blue_o
);

  // Stage 1: clamp, chroma product, sector and position within it.
  logic [h2r_pkg::HUE_W-1:0]   hue_c;
  logic [h2r_pkg::HUE_W-1:0]   base_c;
  logic [h2r_pkg::LEVEL_W-1:0] sat_c;
  logic [h2r_pkg::LEVEL_W-1:0] bri_c;
  h2r_pkg::sector_e            sec_c;
  logic [h2r_pkg::REM_W-1:0]   pos_c;
  logic [h2r_pkg::REM_W-1:0]   xf_c;

  logic [h2r_pkg::LEVEL_W-1:0] bri1_q;
  logic [h2r_pkg::VS_W-1:0]    vs1_q;
  logic [h2r_pkg::REM_W-1:0]   xf1_q;
  h2r_pkg::sector_e            sec1_q;

  always_comb begin
    hue_c = (hue_i >= h2r_pkg::HUE_W'(h2r_pkg::HUE_LIMIT)) ?
            h2r_pkg::HUE_W'(h2r_pkg::HUE_LIMIT - 1) : hue_i;
    sat_c = (saturation_i > h2r_pkg::LEVEL_W'(h2r_pkg::LEVEL_ONE)) ?
            h2r_pkg::LEVEL_W'(h2r_pkg::LEVEL_ONE) : saturation_i;
    bri_c = (brightness_i > h2r_pkg::LEVEL_W'(h2r_pkg::LEVEL_ONE)) ?
            h2r_pkg::LEVEL_W'(h2r_pkg::LEVEL_ONE) : brightness_i;
    if (hue_c >= h2r_pkg::HUE_W'(5 * h2r_pkg::SECTOR_SPAN)) begin
      sec_c  = h2r_pkg::SEC_MAGENTA_RED;
      base_c = h2r_pkg::HUE_W'(5 * h2r_pkg::SECTOR_SPAN);
    end else if (hue_c >= h2r_pkg::HUE_W'(4 * h2r_pkg::SECTOR_SPAN)) begin
      sec_c  = h2r_pkg::SEC_BLUE_MAGENTA;
      base_c = h2r_pkg::HUE_W'(4 * h2r_pkg::SECTOR_SPAN);
    end else if (hue_c >= h2r_pkg::HUE_W'(3 * h2r_pkg::SECTOR_SPAN)) begin
      sec_c  = h2r_pkg::SEC_CYAN_BLUE;
      base_c = h2r_pkg::HUE_W'(3 * h2r_pkg::SECTOR_SPAN);
    end else if (hue_c >= h2r_pkg::HUE_W'(2 * h2r_pkg::SECTOR_SPAN)) begin
      sec_c  = h2r_pkg::SEC_GREEN_CYAN;
      base_c = h2r_pkg::HUE_W'(2 * h2r_pkg::SECTOR_SPAN);
    end else if (hue_c >= h2r_pkg::HUE_W'(h2r_pkg::SECTOR_SPAN)) begin
      sec_c  = h2r_pkg::SEC_YELLOW_GREEN;
      base_c = h2r_pkg::HUE_W'(h2r_pkg::SECTOR_SPAN);
    end else begin
      sec_c  = h2r_pkg::SEC_RED_YELLOW;
      base_c = '0;
    end
    pos_c = h2r_pkg::REM_W'(hue_c - base_c);
    // The intermediate channel follows the position in even sectors and falls in odd ones.
    xf_c  = sec_c[0] ? (h2r_pkg::REM_W'(h2r_pkg::SECTOR_SPAN) - pos_c) : pos_c;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s1) begin
      bri1_q <= bri_c;
      vs1_q  <= h2r_pkg::VS_W'(sat_c) * h2r_pkg::VS_W'(bri_c);
      xf1_q  <= xf_c;
      sec1_q <= sec_c;
    end
  end

  // Stage 2: offset term, partial chroma product and the chroma channel.
  logic [h2r_pkg::CC_W-1:0]   cc_tmp;
  logic [h2r_pkg::VS_W-1:0]   ofs2_q;
  logic [h2r_pkg::NUM_W-1:0]  xp2_q;
  logic [h2r_pkg::CHAN_W-1:0] cch2_q;
  h2r_pkg::sector_e           sec2_q;

  assign cc_tmp = (h2r_pkg::CC_W'(bri1_q) << h2r_pkg::CHAN_W) - h2r_pkg::CC_W'(bri1_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s2) begin
      ofs2_q <= (h2r_pkg::VS_W'(bri1_q) << h2r_pkg::LEVEL_FRAC_BITS) - vs1_q;
      xp2_q  <= h2r_pkg::NUM_W'(vs1_q) * h2r_pkg::NUM_W'(xf1_q);
      cch2_q <= h2r_pkg::CHAN_W'(cc_tmp >> h2r_pkg::LEVEL_FRAC_BITS);
      sec2_q <= sec1_q;
    end
  end

  // Stage 3: numerator of the intermediate channel and the zero channel.
  logic [h2r_pkg::ZC_W-1:0]   zc_tmp;
  logic [h2r_pkg::NUM_W-1:0]  num3_q;
  logic [h2r_pkg::CHAN_W-1:0] cch3_q;
  logic [h2r_pkg::CHAN_W-1:0] zch3_q;
  h2r_pkg::sector_e           sec3_q;

  assign zc_tmp = (h2r_pkg::ZC_W'(ofs2_q) << h2r_pkg::CHAN_W) - h2r_pkg::ZC_W'(ofs2_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s3) begin
      num3_q <= xp2_q + h2r_pkg::NUM_W'(ofs2_q) * h2r_pkg::NUM_W'(h2r_pkg::SECTOR_SPAN);
      zch3_q <= h2r_pkg::CHAN_W'(zc_tmp >> (2 * h2r_pkg::LEVEL_FRAC_BITS));
      cch3_q <= cch2_q;
      sec3_q <= sec2_q;
    end
  end

  // Stage 4: scale by 255 and strip the power-of-two part of the denominator.
  logic [h2r_pkg::T_W-1:0]    scaled;
  logic [h2r_pkg::D_W-1:0]    div4_q;
  logic [h2r_pkg::CHAN_W-1:0] cch4_q;
  logic [h2r_pkg::CHAN_W-1:0] zch4_q;
  h2r_pkg::sector_e           sec4_q;

  assign scaled = (h2r_pkg::T_W'(num3_q) << h2r_pkg::CHAN_W) - h2r_pkg::T_W'(num3_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s4) begin
      div4_q <= h2r_pkg::D_W'(scaled >> h2r_pkg::DIV_SHIFT);
      cch4_q <= cch3_q;
      zch4_q <= zch3_q;
      sec4_q <= sec3_q;
    end
  end

  // Stage 5: reciprocal multiply for the division by fifteen.
  logic [h2r_pkg::P_W-1:0]    prod5_q;
  logic [h2r_pkg::D_W-1:0]    div5_q;
  logic [h2r_pkg::CHAN_W-1:0] cch5_q;
  logic [h2r_pkg::CHAN_W-1:0] zch5_q;
  h2r_pkg::sector_e           sec5_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s5) begin
      prod5_q <= h2r_pkg::P_W'(div4_q) * h2r_pkg::P_W'(h2r_pkg::DIV_MUL);
      div5_q  <= div4_q;
      cch5_q  <= cch4_q;
      zch5_q  <= zch4_q;
      sec5_q  <= sec4_q;
    end
  end

  // Stage 6: correct the quotient, saturate and place the channels.
  logic [h2r_pkg::Q_W-1:0]    quo_est;
  logic [h2r_pkg::Q_W-1:0]    quo;
  logic [h2r_pkg::D_W-1:0]    rem;
  logic [h2r_pkg::CHAN_W-1:0] xch;
  logic [h2r_pkg::CHAN_W-1:0] red_d;
  logic [h2r_pkg::CHAN_W-1:0] green_d;
  logic [h2r_pkg::CHAN_W-1:0] blue_d;
  logic [h2r_pkg::CHAN_W-1:0] red_q;
  logic [h2r_pkg::CHAN_W-1:0] green_q;
  logic [h2r_pkg::CHAN_W-1:0] blue_q;

  always_comb begin
    quo_est = h2r_pkg::Q_W'(prod5_q >> h2r_pkg::RECIP_SHIFT);
    rem     = div5_q - h2r_pkg::D_W'(quo_est) * h2r_pkg::D_W'(h2r_pkg::DIV_BASE);
    // The reciprocal is rounded down, so the estimate may fall one short.
    quo     = (rem >= h2r_pkg::D_W'(h2r_pkg::DIV_BASE)) ? quo_est + 1'b1 : quo_est;
    xch     = (quo > h2r_pkg::Q_W'(h2r_pkg::CHAN_MAX)) ?
              h2r_pkg::CHAN_W'(h2r_pkg::CHAN_MAX) : h2r_pkg::CHAN_W'(quo);
    unique case (sec5_q)
      h2r_pkg::SEC_RED_YELLOW: begin
        red_d = cch5_q; green_d = xch;    blue_d = zch5_q;
      end
      h2r_pkg::SEC_YELLOW_GREEN: begin
        red_d = xch;    green_d = cch5_q; blue_d = zch5_q;
      end
      h2r_pkg::SEC_GREEN_CYAN: begin
        red_d = zch5_q; green_d = cch5_q; blue_d = xch;
      end
      h2r_pkg::SEC_CYAN_BLUE: begin
        red_d = zch5_q; green_d = xch;    blue_d = cch5_q;
      end
      h2r_pkg::SEC_BLUE_MAGENTA: begin
        red_d = xch;    green_d = zch5_q; blue_d = cch5_q;
      end
      default: begin
        red_d = cch5_q; green_d = zch5_q; blue_d = xch;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.s6) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule
